// ===== hw/rtl/ssh_pkg.sv =====
package ssh_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned HASH_W    = 64;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned MODE_W    = 3;
    localparam int unsigned ADLER_W   = 16;
    localparam int unsigned POS_W     = 32;
    localparam int unsigned DJB2_SEED = 5381;
    localparam int unsigned ADLER_MOD = 65521;

    typedef enum logic [MODE_W-1:0] {
        MODE_SDBM   = 3'd0,
        MODE_DJB2   = 3'd1,
        MODE_ADLER  = 3'd2,
        MODE_OAAT   = 3'd3,
        MODE_ROTSUB = 3'd4,
        MODE_MAC    = 3'd5
    } t_mode;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] byte_in;
        logic              last_byte;
    } t_item;

    typedef struct packed {
        logic              valid;
        logic [HASH_W-1:0] hash_value;
    } t_result;

endpackage

// ===== hw/rtl/ssh_if.sv =====
interface ssh_byte_if;
    import ssh_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_in;
    logic              last_byte;
    modport source (output valid, output byte_in, output last_byte, input ready);
    modport sink   (input valid, input byte_in, input last_byte, output ready);
    modport mon    (input valid, input byte_in, input last_byte, input ready);
endinterface

interface ssh_hash_if;
    import ssh_pkg::*;
    logic              valid;
    logic              ready;
    logic [HASH_W-1:0] hash_value;
    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
    modport mon    (input valid, input hash_value, input ready);
endinterface

interface ssh_cfg_if;
    import ssh_pkg::*;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    modport source (output valid, output mode, input ready);
    modport sink   (input valid, input mode, output ready);
    modport mon    (input valid, input mode, input ready);
endinterface

// ===== hw/rtl/ssh_in_stage.sv =====
module ssh_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ssh_byte_if.sink      i_byte,
    input  logic          i_advance,
    output ssh_pkg::t_item o_item
);
    import ssh_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic              take;

    assign i_byte.ready = !r_valid || i_advance;
    assign take         = i_byte.valid && i_byte.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_valid <= i_byte.valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte <= i_byte.byte_in;
            r_last <= i_byte.last_byte;
        end
    end

    assign o_item.valid     = r_valid;
    assign o_item.byte_in   = r_byte;
    assign o_item.last_byte = r_last;

endmodule

// ===== hw/rtl/ssh_core.sv =====
module ssh_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ssh_cfg_if.sink         i_cfg,
    input  ssh_pkg::t_item  i_item,
    input  logic            i_out_room,
    output logic            o_advance,
    output ssh_pkg::t_result o_result
);
    import ssh_pkg::*;

    logic [MODE_W-1:0]  r_mode;
    logic [HASH_W-1:0]  r_hash;
    logic [ADLER_W-1:0] r_lo;
    logic [ADLER_W-1:0] r_hi;
    logic [POS_W-1:0]   r_pos;

    logic               adv;
    logic               first;
    logic [HASH_W-1:0]  h_cur;
    logic [ADLER_W-1:0] lo_cur;
    logic [ADLER_W-1:0] hi_cur;
    logic [ADLER_W:0]   lo_sum;
    logic [ADLER_W:0]   hi_sum;
    logic [ADLER_W-1:0] n_lo;
    logic [ADLER_W-1:0] n_hi;
    logic [HASH_W-1:0]  c64;
    logic [WORD_W-1:0]  c32;
    logic [WORD_W-1:0]  w1;
    logic [WORD_W-1:0]  w2;
    logic [WORD_W-1:0]  w3;
    logic [WORD_W-1:0]  f1;
    logic [WORD_W-1:0]  f2;
    logic [WORD_W-1:0]  f3;
    logic [HASH_W-1:0]  mac_prod;
    logic [HASH_W-1:0]  n_hash;
    logic [HASH_W-1:0]  result;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_SDBM;
        end else if (i_cfg.valid) begin
            r_mode <= i_cfg.mode;
        end
    end

    assign adv   = i_item.valid && (!i_item.last_byte || i_out_room);
    assign first = (r_pos == '0);
    assign c64   = {{(HASH_W-BYTE_W){1'b0}}, i_item.byte_in};
    assign c32   = {{(WORD_W-BYTE_W){1'b0}}, i_item.byte_in};

    // seed is loaded at the first byte of a string
    always_comb begin
        h_cur  = r_hash;
        lo_cur = r_lo;
        hi_cur = r_hi;
        if (first) begin
            h_cur  = (r_mode == MODE_DJB2) ? HASH_W'(DJB2_SEED) : '0;
            lo_cur = ADLER_W'(1);
            hi_cur = '0;
        end
    end

    // adler sums stay below twice the modulus
    always_comb begin
        lo_sum = {1'b0, lo_cur} + (ADLER_W+1)'(i_item.byte_in);
        n_lo   = (lo_sum >= (ADLER_W+1)'(ADLER_MOD)) ?
                 ADLER_W'(lo_sum - (ADLER_W+1)'(ADLER_MOD)) : lo_sum[ADLER_W-1:0];
        hi_sum = {1'b0, hi_cur} + {1'b0, n_lo};
        n_hi   = (hi_sum >= (ADLER_W+1)'(ADLER_MOD)) ?
                 ADLER_W'(hi_sum - (ADLER_W+1)'(ADLER_MOD)) : hi_sum[ADLER_W-1:0];
    end

    assign mac_prod = h_cur * c64;

    always_comb begin
        w1 = h_cur[WORD_W-1:0] + c32;
        w2 = '0;
        w3 = '0;
        case (r_mode)
            MODE_DJB2: begin
                n_hash = (h_cur << 5) + h_cur + c64;
            end
            MODE_ADLER: begin
                n_hash = h_cur;
            end
            MODE_OAAT: begin
                w2     = w1 + (w1 << 10);
                w3     = w2 ^ (w2 >> 6);
                n_hash = {{(HASH_W-WORD_W){1'b0}}, w3};
            end
            MODE_ROTSUB: begin
                w2     = w1 - {w1[WORD_W-14:0], w1[WORD_W-1:WORD_W-13]};
                n_hash = {{(HASH_W-WORD_W){1'b0}}, w2};
            end
            MODE_MAC: begin
                n_hash = mac_prod + c64 + {{(HASH_W-POS_W){1'b0}}, r_pos};
            end
            default: begin
                n_hash = c64 + (h_cur << 6) + (h_cur << 16) - h_cur;
            end
        endcase
    end

    // final mix and result select
    always_comb begin
        f1 = n_hash[WORD_W-1:0] + (n_hash[WORD_W-1:0] << 3);
        f2 = f1 ^ (f1 >> 11);
        f3 = f2 + (f2 << 15);
        case (r_mode)
            MODE_ADLER:  result = {{(HASH_W-2*ADLER_W){1'b0}}, n_hi, n_lo};
            MODE_OAAT:   result = {{(HASH_W-WORD_W){1'b0}}, f3};
            MODE_ROTSUB: result = {{(HASH_W-WORD_W){1'b0}}, n_hash[WORD_W-1:0]};
            default:     result = n_hash;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= '0;
            r_lo   <= ADLER_W'(1);
            r_hi   <= '0;
            r_pos  <= '0;
        end else if (adv) begin
            if (i_item.last_byte) begin
                r_hash <= '0;
                r_lo   <= ADLER_W'(1);
                r_hi   <= '0;
                r_pos  <= '0;
            end else begin
                r_hash <= n_hash;
                r_lo   <= n_lo;
                r_hi   <= n_hi;
                r_pos  <= r_pos + POS_W'(1);
            end
        end
    end

    assign o_advance           = adv;
    assign o_result.valid      = adv && i_item.last_byte;
    assign o_result.hash_value = result;

endmodule

// ===== hw/rtl/ssh_out_stage.sv =====
module ssh_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ssh_pkg::t_result i_result,
    output logic             o_room,
    ssh_hash_if.source       o_hash
);
    import ssh_pkg::*;

    logic              r_valid;
    logic [HASH_W-1:0] r_hash;

    assign o_room = !r_valid || o_hash.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_room) begin
            r_valid <= i_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.valid && o_room) begin
            r_hash <= i_result.hash_value;
        end
    end

    assign o_hash.valid      = r_valid;
    assign o_hash.hash_value = r_hash;

endmodule

// ===== hw/rtl/selectable_string_hash.sv =====
// channel   dir  handshake      payload
// i_byte    in   valid/ready    byte_in[7:0], last_byte
// o_hash    out  valid/ready    hash_value[63:0]
// i_cfg     in   valid/ready    mode[2:0], ready always high
//
// one byte per cycle while o_hash has room; the hash passes both stage registers
// the running state feeds back through the combinational per-mode update
// reset clears the state, the mode to sdbm and both stage valids
// a stall on o_hash holds the result; bytes keep flowing until a last byte waits
module selectable_string_hash (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ssh_byte_if.sink   i_byte,
    ssh_hash_if.source o_hash,
    ssh_cfg_if.sink    i_cfg
);
    import ssh_pkg::*;

    t_item   item;
    t_result res;
    logic    advance;
    logic    out_room;

    ssh_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (i_byte),
        .i_advance (advance),
        .o_item    (item)
    );

    ssh_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (i_cfg),
        .i_item     (item),
        .i_out_room (out_room),
        .o_advance  (advance),
        .o_result   (res)
    );

    ssh_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_result (res),
        .o_room   (out_room),
        .o_hash   (o_hash)
    );

endmodule

// ===== hw/rtl/ssh_checker.sv =====
module ssh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    ssh_byte_if.sink   i_byte,
    ssh_hash_if.source i_hash,
    ssh_cfg_if.sink    i_cfg
);
    import ssh_pkg::*;

    logic [1:0] r_pend;
    logic [1:0] n_pend;

    // strings whose last byte went in and whose hash has not left yet
    always_comb begin
        n_pend = r_pend;
        if (i_byte.valid && i_byte.ready && i_byte.last_byte) begin
            n_pend = n_pend + 2'd1;
        end
        if (i_hash.valid && i_hash.ready) begin
            n_pend = n_pend - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_hash.valid && !i_hash.ready |=> i_hash.valid)
        else $error("hash transfer dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_hash.valid && !i_hash.ready |=> $stable(i_hash.hash_value))
        else $error("hash value changed while stalled");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_hash.valid |-> r_pend != 2'd0)
        else $error("hash without a finished string");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("more strings in flight than stages");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_hash.valid |-> i_byte.ready && i_cfg.ready)
        else $error("input stalled with the output free");

endmodule

bind selectable_string_hash ssh_checker u_ssh_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_byte  (i_byte),
    .i_hash  (o_hash),
    .i_cfg   (i_cfg)
);

// ===== test/tb.sv =====
module tb;
    import ssh_pkg::*;

    class hash_scoreboard;
        logic [MODE_W-1:0]  mode_reg;
        logic [HASH_W-1:0]  run_hash;
        logic [ADLER_W-1:0] sum_low;
        logic [ADLER_W-1:0] sum_high;
        logic [POS_W-1:0]   position;
        logic [HASH_W-1:0]  hash_q[$];
        int                 bytes_seen;
        int                 hashes_checked;
        int                 errors;

        function void clear_string();
            run_hash = '0;
            sum_low  = 16'd1;
            sum_high = '0;
            position = '0;
        endfunction

        function void reset();
            mode_reg       = MODE_SDBM;
            bytes_seen     = 0;
            hashes_checked = 0;
            errors         = 0;
            hash_q.delete();
            clear_string();
        endfunction

        function void set_mode(logic [MODE_W-1:0] m);
            mode_reg = m;
        endfunction

        function int pending();
            return hash_q.size();
        endfunction

        function void note_byte(logic [BYTE_W-1:0] c, logic last);
            logic [MODE_W-1:0] m;
            logic [HASH_W-1:0] h;
            logic [WORD_W-1:0] w;
            logic [HASH_W-1:0] res;
            m = (mode_reg > MODE_MAC) ? MODE_SDBM : mode_reg;
            bytes_seen++;
            if (position == '0) begin
                run_hash = (m == MODE_DJB2) ? 64'(DJB2_SEED) : '0;
                sum_low  = 16'd1;
                sum_high = '0;
            end
            h = run_hash;
            w = h[WORD_W-1:0];
            sum_low  = 16'((32'(sum_low) + 32'(c)) % ADLER_MOD);
            sum_high = 16'((32'(sum_high) + 32'(sum_low)) % ADLER_MOD);
            case (m)
                MODE_DJB2: begin
                    h = h * 64'd33 + 64'(c);
                end
                MODE_ADLER: begin
                end
                MODE_OAAT: begin
                    w = w + 32'(c);
                    w = w + (w << 10);
                    w = w ^ (w >> 6);
                    h = 64'(w);
                end
                MODE_ROTSUB: begin
                    w = w + 32'(c);
                    w = w - {w[18:0], w[31:19]};
                    h = 64'(w);
                end
                MODE_MAC: begin
                    h = h * 64'(c) + 64'(c) + 64'(position);
                end
                default: begin
                    h = 64'(c) + (h << 6) + (h << 16) - h;
                end
            endcase
            run_hash = h;
            position = position + 1'b1;
            if (last) begin
                case (m)
                    MODE_ADLER: res = {32'b0, sum_high, sum_low};
                    MODE_OAAT: begin
                        w = h[WORD_W-1:0];
                        w = w + (w << 3);
                        w = w ^ (w >> 11);
                        w = w + (w << 15);
                        res = 64'(w);
                    end
                    MODE_ROTSUB: res = 64'(h[WORD_W-1:0]);
                    default: res = h;
                endcase
                hash_q.push_back(res);
                clear_string();
            end
        endfunction

        function void check_hash(logic [HASH_W-1:0] actual);
            logic [HASH_W-1:0] exp_hash;
            if (hash_q.size() == 0) begin
                $error("hash_value: unexpected transfer, actual %h", actual);
                errors++;
                return;
            end
            exp_hash = hash_q.pop_front();
            hashes_checked++;
            if (actual !== exp_hash) begin
                $error("hash_value mismatch: expected %h, actual %h", exp_hash, actual);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   sender_gaps;
    bit   receiver_stalls;
    int   mode_writes;
    int   sent_bytes;

    hash_scoreboard sb;

    ssh_byte_if byte_ch();
    ssh_hash_if hash_ch();
    ssh_cfg_if  cfg_ch();

    selectable_string_hash i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_hash  (hash_ch),
        .i_cfg   (cfg_ch)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // one monitor, fixed order: result first, then input, then config
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (hash_ch.valid === 1'b1 && hash_ch.ready === 1'b1) begin
                sb.check_hash(hash_ch.hash_value);
            end
            if (byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1) begin
                sb.note_byte(byte_ch.byte_in, byte_ch.last_byte);
            end
            if (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) begin
                sb.set_mode(cfg_ch.mode);
            end
        end
    end

    initial begin
        hash_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (receiver_stalls && $urandom_range(0, 4) == 0) begin
                hash_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 8)) @(negedge i_clk);
            end else begin
                hash_ch.ready <= 1'b1;
            end
        end
    end

    function automatic logic [BYTE_W-1:0] rand_byte();
        if ($urandom_range(0, 15) == 0) begin
            return 8'h00;
        end
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        @(negedge i_clk);
        if (sender_gaps && $urandom_range(0, 4) == 0) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.byte_in   <= b;
        byte_ch.last_byte <= last;
        do @(posedge i_clk); while (byte_ch.ready !== 1'b1);
        sent_bytes++;
    endtask

    task automatic wait_hashes_drained();
        @(negedge i_clk);
        byte_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] m);
        wait_hashes_drained();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.mode  <= m;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        mode_writes++;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_string(input int len, input int switch_at);
        for (int i = 0; i < len; i++) begin
            if (i == switch_at) begin
                write_mode(3'($urandom_range(0, 7)));
            end
            send_byte(rand_byte(), i == len - 1);
        end
    endtask

    initial begin
        int phase_bytes;
        int len;
        int switch_at;
        sb = new();
        sb.reset();
        mode_writes       = 0;
        sent_bytes        = 0;
        sender_gaps       = 1'b1;
        receiver_stalls   = 1'b1;
        i_rst_n           = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.byte_in   = '0;
        byte_ch.last_byte = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.mode       = MODE_SDBM;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset mode, then every mode value including the unused ones
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b1);
        for (int m = 1; m < 8; m++) begin
            write_mode(3'(m));
            send_byte(8'hFF, 1'b0);
            send_byte(8'h00, 1'b0);
            send_byte(8'h80, 1'b1);
        end
        // mode switch inside a string keeps the djb2 seed
        write_mode(MODE_DJB2);
        send_byte(8'h55, 1'b0);
        write_mode(MODE_ROTSUB);
        send_byte(8'hAA, 1'b1);

        for (int p = 0; p < 6; p++) begin
            sender_gaps     = (p == 0 || p == 1 || p == 4);
            receiver_stalls = (p == 0 || p == 3 || p == 4);
            if (p == 4) begin
                wait_hashes_drained();
            end
            phase_bytes = 0;
            while (phase_bytes < 100) begin
                // last phase runs back to back with no mode writes
                if (p != 5 && $urandom_range(0, 3) == 0) begin
                    write_mode(3'($urandom_range(0, 7)));
                end
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
                switch_at = (p != 5 && $urandom_range(0, 9) == 0) ?
                            $urandom_range(1, len) : -1;
                send_string(len, switch_at);
                phase_bytes += len;
            end
        end

        wait_hashes_drained();
        repeat (10) @(posedge i_clk);
        $display("hashed %0d bytes into %0d checked results", sent_bytes, sb.hashes_checked);
        $display("%0d mode writes, all six modes plus unused codes, mid-string switches",
                 mode_writes);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/ssh_pkg.sv
hw/rtl/ssh_if.sv
hw/rtl/ssh_in_stage.sv
hw/rtl/ssh_core.sv
hw/rtl/ssh_out_stage.sv
hw/rtl/selectable_string_hash.sv
hw/rtl/ssh_checker.sv
test/tb.sv
